/* rtl/btpc_pkg.sv */
// btpc_pkg: shared widths, register indexes and constants for the
// barometric temperature/pressure compensation pipeline.
// No dependencies.
`default_nettype none

package btpc_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 20;
    localparam int PRESS_W = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Pipeline depth (register stages, output register included)
    localparam int NUM_STAGES = 9;

    // Calibration register indexes (paddr[4:2])
    localparam logic [2:0] REG_C1 = 3'd0;
    localparam logic [2:0] REG_C2 = 3'd1;
    localparam logic [2:0] REG_C3 = 3'd2;
    localparam logic [2:0] REG_C4 = 3'd3;
    localparam logic [2:0] REG_C5 = 3'd4;
    localparam logic [2:0] REG_C6 = 3'd5;

    // Temperature thresholds in hundredths of a degree
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -20'sd1500;

    // Pressure saturation limits
    localparam logic [PRESS_W-1:0] PRESS_MAX = 32'h7FFF_FFFF;
    localparam logic [PRESS_W-1:0] PRESS_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

/* rtl/baro_temp_pressure_compensation.sv */
// baro_temp_pressure_compensation: pipelined first/second-order temperature
// compensation of raw barometric readings. Depends on btpc_pkg.
//
//  channel   handshake                  payload
//  -------   -------------------------  -----------------------------------
//  raw       raw_valid / raw_ready      raw_pressure, raw_temperature
//  comp      comp_valid / comp_ready    temperature, pressure
//  config    APB psel/penable/pwrite    paddr[4:2] = calibration word index
//
// One reading pair enters per cycle while raw_ready is high; the pipeline
// has nine register stages (the widest step is the 66-bit pressure product,
// split into two partial products over two stages).
// rst_n clears all stage valid bits and the calibration words.
// A stall at comp_ready holds the output register; stages behind it keep
// moving until they meet an occupied stage, so raw_ready stays high while
// any bubble is left in the pipeline.
`default_nettype none

module baro_temp_pressure_compensation (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // raw readings
    input  wire logic                              raw_valid,
    output logic                                   raw_ready,
    input  wire logic [btpc_pkg::RAW_W-1:0]        raw_pressure,
    input  wire logic [btpc_pkg::RAW_W-1:0]        raw_temperature,
    // compensated results
    output logic                                   comp_valid,
    input  wire logic                              comp_ready,
    output logic signed [btpc_pkg::TEMP_W-1:0]     temperature,
    output logic signed [btpc_pkg::PRESS_W-1:0]    pressure,
    // calibration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [btpc_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [btpc_pkg::DATA_W-1:0]       pwdata,
    output logic [btpc_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);
    import btpc_pkg::*;

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_C1:  c1_reg <= pwdata[CAL_W-1:0];
                REG_C2:  c2_reg <= pwdata[CAL_W-1:0];
                REG_C3:  c3_reg <= pwdata[CAL_W-1:0];
                REG_C4:  c4_reg <= pwdata[CAL_W-1:0];
                REG_C5:  c5_reg <= pwdata[CAL_W-1:0];
                REG_C6:  c6_reg <= pwdata[CAL_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (cfg_idx)
            REG_C1:  prdata = {16'h0000, c1_reg};
            REG_C2:  prdata = {16'h0000, c2_reg};
            REG_C3:  prdata = {16'h0000, c3_reg};
            REG_C4:  prdata = {16'h0000, c4_reg};
            REG_C5:  prdata = {16'h0000, c5_reg};
            REG_C6:  prdata = {16'h0000, c6_reg};
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when it is empty or its
    // successor loads.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || comp_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = raw_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign raw_ready  = stage_en[0];
    assign comp_valid = valid_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 0: dT = D2 - C5*256
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]  d1_0_reg;
    logic signed [24:0] dt_0_reg, dt_0_next;

    assign dt_0_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_reg, 8'h00});

    // ------------------------------------------------------------------
    // Stage 1: the four dT products
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]   d1_1_reg;
    logic signed [41:0] mt_1_reg, mt_1_next;      // dT*C6
    logic signed [41:0] moff_1_reg, moff_1_next;  // C4*dT
    logic signed [41:0] msens_1_reg, msens_1_next; // C3*dT
    logic [48:0]        mdd_1_reg, mdd_1_next;    // dT*dT
    logic signed [49:0] dt_sq;

    always_comb
    begin
        mt_1_next    = 42'(dt_0_reg) * 42'($signed({1'b0, c6_reg}));
        moff_1_next  = 42'(dt_0_reg) * 42'($signed({1'b0, c4_reg}));
        msens_1_next = 42'(dt_0_reg) * 42'($signed({1'b0, c3_reg}));
        dt_sq        = 50'(dt_0_reg) * 50'(dt_0_reg);
        mdd_1_next   = dt_sq[48:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: TEMP, OFF, SENS, T2
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          d1_2_reg;
    logic signed [TEMP_W-1:0]  temp_2_reg, temp_2_next;
    logic signed [39:0]        off_2_reg, off_2_next;
    logic signed [39:0]        sens_2_reg, sens_2_next;
    logic [17:0]               t2_2_reg, t2_2_next;

    always_comb
    begin
        temp_2_next = 20'(mt_1_reg >>> 23) + TEMP_REF;
        off_2_next  = 40'($signed({1'b0, c2_reg, 16'h0000})) + 40'(moff_1_reg >>> 7);
        sens_2_next = 40'($signed({1'b0, c1_reg, 15'h0000})) + 40'(msens_1_reg >>> 8);
        t2_2_next   = mdd_1_reg[48:31];
    end

    // ------------------------------------------------------------------
    // Stage 3: low-temperature flags, squares, final temperature
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          d1_3_reg;
    logic signed [TEMP_W-1:0]  temp_3_reg, temp_3_next;
    logic signed [39:0]        off_3_reg;
    logic signed [39:0]        sens_3_reg;
    logic [35:0]               aa_3_reg, aa_3_next;
    logic [35:0]               bb_3_reg, bb_3_next;
    logic                      low_3_reg, low_3_next;
    logic                      vlow_3_reg, vlow_3_next;
    logic signed [TEMP_W-1:0]  dev_a, dev_b;
    logic signed [39:0]        sq_a, sq_b;

    always_comb
    begin
        dev_a       = temp_2_reg - TEMP_REF;
        dev_b       = temp_2_reg - TEMP_VLOW;
        sq_a        = 40'(dev_a) * 40'(dev_a);
        sq_b        = 40'(dev_b) * 40'(dev_b);
        aa_3_next   = sq_a[35:0];
        bb_3_next   = sq_b[35:0];
        low_3_next  = temp_2_reg < TEMP_REF;
        vlow_3_next = temp_2_reg < TEMP_VLOW;
        // T2 only applies in the low-temperature range
        if (low_3_next)
        begin
            temp_3_next = temp_2_reg - $signed({2'b00, t2_2_reg});
        end
        else
        begin
            temp_3_next = temp_2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: OFF2, SENS2
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          d1_4_reg;
    logic signed [TEMP_W-1:0]  temp_4_reg;
    logic signed [39:0]        off_4_reg;
    logic signed [39:0]        sens_4_reg;
    logic [38:0]               off2_4_reg, off2_4_next;
    logic [38:0]               sens2_4_reg, sens2_4_next;

    always_comb
    begin
        off2_4_next  = '0;
        sens2_4_next = '0;
        if (low_3_reg)
        begin
            off2_4_next  = 39'(aa_3_reg[35:1]) * 39'd5;
            sens2_4_next = 39'(aa_3_reg[35:2]) * 39'd5;
            if (vlow_3_reg)
            begin
                off2_4_next  = off2_4_next + 39'(bb_3_reg) * 39'd7;
                sens2_4_next = sens2_4_next + 39'(bb_3_reg[35:1]) * 39'd11;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: corrected OFF and SENS
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]          d1_5_reg;
    logic signed [TEMP_W-1:0]  temp_5_reg;
    logic signed [41:0]        offf_5_reg, offf_5_next;
    logic signed [41:0]        sensf_5_reg, sensf_5_next;

    always_comb
    begin
        offf_5_next  = 42'(off_4_reg) - $signed({3'b000, off2_4_reg});
        sensf_5_next = 42'(sens_4_reg) - $signed({3'b000, sens2_4_reg});
    end

    // ------------------------------------------------------------------
    // Stage 6: D1*SENS as two partial products (low half unsigned)
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0]  temp_6_reg;
    logic signed [41:0]        offf_6_reg;
    logic [44:0]               pplo_6_reg, pplo_6_next;
    logic signed [45:0]        pphi_6_reg, pphi_6_next;
    logic signed [20:0]        sens_hi;

    always_comb
    begin
        sens_hi     = $signed(sensf_5_reg[41:21]);
        pplo_6_next = 45'(d1_5_reg) * 45'(sensf_5_reg[20:0]);
        pphi_6_next = 46'($signed({1'b0, d1_5_reg})) * 46'(sens_hi);
    end

    // ------------------------------------------------------------------
    // Stage 7: (D1*SENS) >> 21, folded from the partial products
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0]  temp_7_reg;
    logic signed [41:0]        offf_7_reg;
    logic signed [46:0]        q_7_reg, q_7_next;

    assign q_7_next = 47'(pphi_6_reg) + $signed({23'b0, pplo_6_reg[44:21]});

    // ------------------------------------------------------------------
    // Stage 8: subtract OFF, shift, saturate into the output register
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0]  temp_8_reg;
    logic [PRESS_W-1:0]        press_8_reg, press_8_next;
    logic signed [47:0]        p_diff;
    logic [32:0]               p_wide;

    always_comb
    begin
        p_diff = 48'(q_7_reg) - 48'(offf_7_reg);
        p_wide = p_diff[47:15];
        if (p_wide[32] != p_wide[31])
        begin
            press_8_next = p_wide[32] ? PRESS_MIN : PRESS_MAX;
        end
        else
        begin
            press_8_next = p_wide[31:0];
        end
    end

    assign temperature = temp_8_reg;
    assign pressure    = $signed(press_8_reg);

    // ------------------------------------------------------------------
    // Stage payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            d1_0_reg <= raw_pressure;
            dt_0_reg <= dt_0_next;
        end
        if (stage_en[1])
        begin
            d1_1_reg    <= d1_0_reg;
            mt_1_reg    <= mt_1_next;
            moff_1_reg  <= moff_1_next;
            msens_1_reg <= msens_1_next;
            mdd_1_reg   <= mdd_1_next;
        end
        if (stage_en[2])
        begin
            d1_2_reg   <= d1_1_reg;
            temp_2_reg <= temp_2_next;
            off_2_reg  <= off_2_next;
            sens_2_reg <= sens_2_next;
            t2_2_reg   <= t2_2_next;
        end
        if (stage_en[3])
        begin
            d1_3_reg   <= d1_2_reg;
            temp_3_reg <= temp_3_next;
            off_3_reg  <= off_2_reg;
            sens_3_reg <= sens_2_reg;
            aa_3_reg   <= aa_3_next;
            bb_3_reg   <= bb_3_next;
            low_3_reg  <= low_3_next;
            vlow_3_reg <= vlow_3_next;
        end
        if (stage_en[4])
        begin
            d1_4_reg    <= d1_3_reg;
            temp_4_reg  <= temp_3_reg;
            off_4_reg   <= off_3_reg;
            sens_4_reg  <= sens_3_reg;
            off2_4_reg  <= off2_4_next;
            sens2_4_reg <= sens2_4_next;
        end
        if (stage_en[5])
        begin
            d1_5_reg    <= d1_4_reg;
            temp_5_reg  <= temp_4_reg;
            offf_5_reg  <= offf_5_next;
            sensf_5_reg <= sensf_5_next;
        end
        if (stage_en[6])
        begin
            temp_6_reg <= temp_5_reg;
            offf_6_reg <= offf_5_reg;
            pplo_6_reg <= pplo_6_next;
            pphi_6_reg <= pphi_6_next;
        end
        if (stage_en[7])
        begin
            temp_7_reg <= temp_6_reg;
            offf_7_reg <= offf_6_reg;
            q_7_reg    <= q_7_next;
        end
        if (stage_en[8])
        begin
            temp_8_reg  <= temp_7_reg;
            press_8_reg <= press_8_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input back-pressure only when every stage is full and output stalled
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !raw_ready |-> (&valid_reg && !comp_ready))
        else $error("raw_ready low with a free pipeline slot");

    // an item advancing from stage 0 lands in stage 1
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[0] && stage_en[1]) |=> valid_reg[1])
        else $error("transaction lost between stage 0 and stage 1");

    // a blocked stage 7 keeps its transaction and payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[7] && !stage_en[8]) |=> (valid_reg[7] && $stable(q_7_reg)))
        else $error("stalled stage 7 dropped or changed its transaction");

    // very-low range implies the low range
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && vlow_3_reg) |-> low_3_reg)
        else $error("very-low flag set without low flag");

endmodule

`default_nettype wire

/* dv/baro_temp_pressure_compensation_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for baro_temp_pressure_compensation.
// Depends on btpc_pkg and the block's RTL; predicts every compensated reading
// from the calibration words it has written and checks results in order.

module baro_temp_pressure_compensation_tb;

    import btpc_pkg::*;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  temperature;
        logic signed [PRESS_W-1:0] pressure;
    } comp_reading_t;

    // Register indexes past the last calibration word
    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;

    localparam longint PRESS_HI = 64'sd2147483647;
    localparam longint PRESS_LO = -64'sd2147483648;

    localparam int QUIET_LIMIT  = 5000;
    localparam int REPORT_LIMIT = 10;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      raw_valid = 1'b0;
    logic                      raw_ready;
    logic [RAW_W-1:0]          raw_pressure = '0;
    logic [RAW_W-1:0]          raw_temperature = '0;
    logic                      comp_valid;
    logic                      comp_ready = 1'b0;
    logic signed [TEMP_W-1:0]  temperature;
    logic signed [PRESS_W-1:0] pressure;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    // Calibration words as the block should hold them
    logic [CAL_W-1:0] cal_word [6];

    comp_reading_t expected_readings [$];
    int            mismatches = 0;
    int            quiet_cycles = 0;
    int            send_idle_pct = 37;
    int            stall_pct = 37;

    baro_temp_pressure_compensation u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .raw_valid       (raw_valid),
        .raw_ready       (raw_ready),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .comp_valid      (comp_valid),
        .comp_ready      (comp_ready),
        .temperature     (temperature),
        .pressure        (pressure),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Compensated temperature and pressure for one reading pair
    function automatic comp_reading_t compensate_reading(input logic [RAW_W-1:0] raw_p,
                                                         input logic [RAW_W-1:0] raw_t);
        longint        d1, d2, k1, k2, k3, k4, k5, k6;
        longint        dt, t_comp, offset, sens, t2, off2, sens2, delta, below, p;
        comp_reading_t r;
        d1 = longint'(raw_p);
        d2 = longint'(raw_t);
        k1 = longint'(cal_word[REG_C1]);
        k2 = longint'(cal_word[REG_C2]);
        k3 = longint'(cal_word[REG_C3]);
        k4 = longint'(cal_word[REG_C4]);
        k5 = longint'(cal_word[REG_C5]);
        k6 = longint'(cal_word[REG_C6]);
        // first order
        dt     = d2 - k5 * 256;
        t_comp = longint'(TEMP_REF) + ((dt * k6) >>> 23);
        offset = k2 * 65536 + ((k4 * dt) >>> 7);
        sens   = k1 * 32768 + ((k3 * dt) >>> 8);
        // second order, both bands judged on the first-order temperature
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        if (t_comp < longint'(TEMP_REF))
        begin
            delta = t_comp - longint'(TEMP_REF);
            t2    = (dt * dt) >>> 31;
            off2  = 5 * ((delta * delta) >>> 1);
            sens2 = 5 * ((delta * delta) >>> 2);
            if (t_comp < longint'(TEMP_VLOW))
            begin
                below = t_comp - longint'(TEMP_VLOW);
                off2  += 7 * below * below;
                sens2 += 11 * ((below * below) >>> 1);
            end
        end
        t_comp -= t2;
        p = (((d1 * (sens - sens2)) >>> 21) - (offset - off2)) >>> 15;
        if (p > PRESS_HI)
            p = PRESS_HI;
        if (p < PRESS_LO)
            p = PRESS_LO;
        r.temperature = t_comp[TEMP_W-1:0];
        r.pressure    = p[PRESS_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Result checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin : check_results
        comp_reading_t want;
        if (rst_n && comp_valid && comp_ready)
        begin
            if (expected_readings.size() == 0)
                note_mismatch("result with nothing expected", 0, longint'(temperature));
            else
            begin
                want = expected_readings.pop_front();
                if (temperature !== want.temperature)
                    note_mismatch("temperature", longint'(want.temperature),
                                  longint'(temperature));
                if (pressure !== want.pressure)
                    note_mismatch("pressure", longint'(want.pressure), longint'(pressure));
            end
        end
    end

    // Receiver stalls
    always @(negedge clk)
        comp_ready <= ($urandom_range(99) >= stall_pct);

    // Count cycles without any transaction
    always @(posedge clk)
    begin
        if ((raw_valid && raw_ready) || (comp_valid && comp_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("baro_temp_pressure_compensation verification failed");
        $finish;
    end

    // Send one reading pair; valid stays up after acceptance until the next call
    task automatic send_reading(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            raw_valid <= 1'b0;
            @(negedge clk);
        end
        raw_valid       <= 1'b1;
        raw_pressure    <= raw_p;
        raw_temperature <= raw_t;
        @(posedge clk);
        while (!raw_ready)
            @(posedge clk);
        expected_readings.push_back(compensate_reading(raw_p, raw_t));
        @(negedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        raw_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_readings.size() != 0);
    endtask

    // APB write with random upper data bits; only the low 16 bits are kept
    task automatic write_cal(input logic [2:0] idx, input logic [CAL_W-1:0] value);
        logic [DATA_W-1:0] word;
        word = $urandom;
        word[CAL_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        if (idx <= REG_C6)
            cal_word[idx] = value;
    endtask

    task automatic set_calibration(input logic [CAL_W-1:0] c1, input logic [CAL_W-1:0] c2,
                                   input logic [CAL_W-1:0] c3, input logic [CAL_W-1:0] c4,
                                   input logic [CAL_W-1:0] c5, input logic [CAL_W-1:0] c6);
        write_cal(REG_C1, c1);
        write_cal(REG_C2, c2);
        write_cal(REG_C3, c3);
        write_cal(REG_C4, c4);
        write_cal(REG_C5, c5);
        write_cal(REG_C6, c6);
    endtask

    // Read back all six words over APB
    task automatic check_cal_readback();
        logic [DATA_W-1:0] data;
        for (int i = int'(REG_C1); i <= int'(REG_C6); i++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(i), 2'b00};
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            data = prdata;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge clk);
            if (data[CAL_W-1:0] !== cal_word[i])
                note_mismatch("calibration readback", longint'(cal_word[i]),
                              longint'(data[CAL_W-1:0]));
        end
    endtask

    // Registers still zero after reset: formula applied as is
    task automatic test_uncalibrated();
        check_cal_readback();
        send_reading(24'h000000, 24'h000000);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'h800000, 24'h123456);
        drain_results();
    endtask

    // Writes, readback, and writes to indexes past the last word
    task automatic test_register_access();
        set_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        check_cal_readback();
        write_cal(REG_UNUSED_LO, 16'hA5A5);
        write_cal(REG_UNUSED_HI, 16'h5A5A);
        check_cal_readback();
    endtask

    // Temperature bands around 20.00 and -15.00 degrees with typical calibration
    task automatic test_temperature_bands();
        send_reading(24'd9085466, 24'd8566784);   // exactly 20.00, no correction
        send_reading(24'd0,       24'd8566783);   // just below 20.00
        send_reading(24'hFFFFFF,  24'd8569150);   // room temperature
        send_reading(24'd9085466, 24'd7529764);   // exactly -15.00
        send_reading(24'h800000,  24'd7529763);   // just below -15.00
        send_reading(24'hFFFFFF,  24'h000000);    // deep cold
        send_reading(24'h000000,  24'hFFFFFF);    // hottest reading
        drain_results();
    endtask

    // Extreme calibration words and extreme readings
    task automatic test_calibration_extremes();
        set_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(24'hFFFFFF, 24'h000000);
        send_reading(24'h000000, 24'hFFFFFF);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        drain_results();
        // highest temperature: no reference offset, steepest slope
        write_cal(REG_C5, 16'h0000);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        drain_results();
        // largest negative pressure terms
        set_calibration(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_reading(24'hFFFFFF, 24'h000000);
        drain_results();
        set_calibration(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_reading(24'hFFFFFF, 24'h000000);
        drain_results();
    endtask

    // Random readings over several random calibration sets
    task automatic test_random_readings();
        longint           center, jitter, t_val;
        logic [RAW_W-1:0] p_val;
        logic [CAL_W-1:0] word;
        for (int phase = 0; phase < 6; phase++)
        begin
            // first phase runs with no idling on either side
            send_idle_pct = (phase == 0) ? 0 : 37;
            stall_pct     = (phase == 0) ? 0 : 37;
            for (int i = int'(REG_C1); i <= int'(REG_C6); i++)
            begin
                case ($urandom_range(9))
                    0:       word = 16'h0000;
                    1:       word = 16'hFFFF;
                    default: word = CAL_W'($urandom);
                endcase
                write_cal(3'(i), word);
            end
            center = longint'(cal_word[REG_C5]) * 256;
            for (int n = 0; n < 214; n++)
            begin
                // let the pipeline run dry once in mid-stream
                if (phase == 3 && n == 107)
                    drain_results();
                case ($urandom_range(3))
                    0: t_val = longint'($urandom_range(32'h00FF_FFFF));
                    1:
                    begin
                        jitter = longint'($urandom_range(131072));
                        t_val  = center + jitter - 65536;
                    end
                    2: t_val = longint'($urandom_range(32'(center)));
                    default: t_val = ($urandom_range(1) != 0) ? 64'sh00FF_FFFF : 64'sd0;
                endcase
                if (t_val < 0)
                    t_val = 0;
                if (t_val > 64'sh00FF_FFFF)
                    t_val = 64'sh00FF_FFFF;
                if ($urandom_range(9) == 0)
                    p_val = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
                else
                    p_val = RAW_W'($urandom);
                send_reading(p_val, t_val[RAW_W-1:0]);
            end
            drain_results();
        end
    endtask

    initial
    begin
        foreach (cal_word[i])
            cal_word[i] = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_uncalibrated();
        test_register_access();
        test_temperature_bands();
        test_calibration_extremes();
        test_random_readings();

        // settle, catching any stray result
        repeat (4 * NUM_STAGES)
            @(negedge clk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("baro_temp_pressure_compensation verification clean");
        else
            $display("baro_temp_pressure_compensation verification failed");
        $finish;
    end

endmodule
